@@ design/bmhq_pkg.sv @@
// Package for the binary max-heap queue: payload structs, codes and sizes.
// No dependencies; used by every module of the block.
package bmhq_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CH_W     = ADDR_W + 2;
  localparam int ITEM_W   = 7;

  // Input action codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_PEEK   = 2'd2;

  // Classified operations
  localparam logic [1:0] OP_INS  = 2'd0;
  localparam logic [1:0] OP_REM  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;
  localparam logic [1:0] OP_NOP  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] value;
  } bmhq_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic [ITEM_W-1:0]  item_count;
  } bmhq_out_t;

  // Command passed from front to back
  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
  } bmhq_cmd_t;

endpackage

@@ design/bmhq_front.sv @@
// Front end: accepts items, classifies the action, buffers commands in a two-entry queue.
// Depends on bmhq_pkg.
module bmhq_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  bmhq_pkg::bmhq_in_t  in_data,
  output logic                cmd_valid,
  input  logic                cmd_take,
  output bmhq_pkg::bmhq_cmd_t cmd
);
  import bmhq_pkg::*;

  bmhq_cmd_t  q_r [2];
  logic       rd_ptr_r, wr_ptr_r;
  logic [1:0] cnt_r;
  bmhq_cmd_t  cls;
  logic       push_ok, pop_ok;

  // Classify the action code
  always_comb begin
    cls.value = in_data.value;
    unique case (in_data.action)
      ACT_INSERT: cls.op = OP_INS;
      ACT_REMOVE: cls.op = OP_REM;
      ACT_PEEK:   cls.op = OP_PEEK;
      default:    cls.op = OP_NOP;
    endcase
  end

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = cmd_take && cmd_valid;

  // Queue storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push_ok) wr_ptr_r <= !wr_ptr_r;
      if (pop_ok)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push_ok} - {1'b0, pop_ok};
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("command queue count out of range");
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !pop_ok) |=> in_full) else $error("full flag dropped");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push_ok && !pop_ok) |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("queue count not updated on transfer");
`endif

endmodule

@@ design/bmhq_back.sv @@
// Back end: heap engine with its entry memory; sifts up on insert and down on remove.
// Depends on bmhq_pkg.
module bmhq_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  output logic                 cmd_take,
  input  bmhq_pkg::bmhq_cmd_t  cmd,
  output logic                 res_valid,
  input  logic                 res_take,
  output bmhq_pkg::bmhq_out_t  res
);
  import bmhq_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LAST  = 3'd1;
  localparam logic [2:0] S_LASTD = 3'd2;
  localparam logic [2:0] S_DRD   = 3'd3;
  localparam logic [2:0] S_DCMP  = 3'd4;
  localparam logic [2:0] S_URD   = 3'd5;
  localparam logic [2:0] S_UCMP  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] rd0_r, rd1_r, root_r;

  logic [2:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]  pos_r, pos_nxt;
  logic signed [31:0] key_r, key_nxt, res_val_r, res_val_nxt;
  logic [1:0]         st_r, st_nxt;

  logic [ADDR_W-1:0]  raddr0, raddr1, waddr, parent;
  logic               we;
  logic signed [31:0] wdata, pick_val;
  logic [CH_W-1:0]    lchild, rchild, cnt_ext;
  logic               pick_r;

  assign cnt_ext = CH_W'(cnt_r);
  assign lchild  = {1'b0, pos_r, 1'b1};
  assign rchild  = lchild + CH_W'(1);
  assign parent  = ADDR_W'((pos_r - ADDR_W'(1)) >> 1);
  // Right child wins ties and is taken when it exists and left is not larger
  assign pick_r   = (rchild < cnt_ext) && !(rd0_r > rd1_r);
  assign pick_val = pick_r ? rd1_r : rd0_r;

  // Entry memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd0_r <= mem[raddr0];
    rd1_r <= mem[raddr1];
  end

  // Copy of the root entry
  always_ff @(posedge clk) begin
    if (we && waddr == '0) root_r <= wdata;
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    pos_nxt     = pos_r;
    key_nxt     = key_r;
    res_val_nxt = res_val_r;
    st_nxt      = st_r;
    raddr0      = '0;
    raddr1      = '0;
    we          = 1'b0;
    waddr       = pos_r;
    wdata       = key_r;
    cmd_take    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_take    = 1'b1;
          res_val_nxt = '0;
          st_nxt      = ST_OK;
          state_nxt   = S_DONE;
          unique case (cmd.op)
            OP_INS: begin
              if (cnt_r == CNT_W'(CAPACITY)) begin
                st_nxt = ST_FULL;
              end else begin
                key_nxt   = cmd.value;
                pos_nxt   = ADDR_W'(cnt_r);
                cnt_nxt   = cnt_r + CNT_W'(1);
                state_nxt = S_URD;
              end
            end
            OP_REM: begin
              if (cnt_r == '0) begin
                st_nxt = ST_EMPTY;
              end else begin
                res_val_nxt = root_r;
                cnt_nxt     = cnt_r - CNT_W'(1);
                state_nxt   = S_LAST;
              end
            end
            OP_PEEK: begin
              if (cnt_r == '0) st_nxt = ST_EMPTY;
              else             res_val_nxt = root_r;
            end
            default: ;
          endcase
        end
      end
      S_LAST: begin
        raddr0    = ADDR_W'(cnt_r);
        state_nxt = S_LASTD;
      end
      S_LASTD: begin
        key_nxt = rd0_r;
        pos_nxt = '0;
        state_nxt = (cnt_r == '0) ? S_DONE : S_DRD;
      end
      S_DRD: begin
        if (lchild >= cnt_ext) begin
          we        = 1'b1;
          state_nxt = S_DONE;
        end else begin
          raddr0    = lchild[ADDR_W-1:0];
          raddr1    = rchild[ADDR_W-1:0];
          state_nxt = S_DCMP;
        end
      end
      S_DCMP: begin
        we = 1'b1;
        if (pick_val > key_r) begin
          wdata     = pick_val;
          pos_nxt   = pick_r ? rchild[ADDR_W-1:0] : lchild[ADDR_W-1:0];
          state_nxt = S_DRD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_URD: begin
        if (pos_r == '0) begin
          we        = 1'b1;
          state_nxt = S_DONE;
        end else begin
          raddr0    = parent;
          state_nxt = S_UCMP;
        end
      end
      S_UCMP: begin
        we = 1'b1;
        if (key_r > rd0_r) begin
          wdata     = rd0_r;
          pos_nxt   = parent;
          state_nxt = S_URD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    key_r     <= key_nxt;
    res_val_r <= res_val_nxt;
    st_r      <= st_nxt;
  end

  assign res_valid        = (state_r == S_DONE);
  assign res.result_value = res_val_r;
  assign res.status       = st_r;
  assign res.item_count   = ITEM_W'(cnt_r);

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY)) else $error("entry count above capacity");
  a_down_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DCMP) |-> (lchild < cnt_ext)) else $error("sift-down past last entry");
  a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_take) |=> (state_r == S_IDLE)) else $error("result not released");
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |=> (state_r != S_IDLE)) else $error("command taken without work");
`endif

endmodule

@@ design/binary_max_heap_queue_unit.sv @@
// Top level of the binary max-heap queue: front, back and the result register.
// Depends on bmhq_pkg, bmhq_front and bmhq_back.
//
//   channel  | handshake         | payload
//   input    | in_push / in_full | in_data  (action, value)
//   result   | out_pop/out_empty | out_data (result_value, status, item_count)
//
// Peek, no-op and rejected items go straight to the result without touching the entry
// memory; an insert or remove runs one read-compare-write step per heap level
// on the entry memory (one write and two registered reads a cycle).
// Reset is synchronous, active low, and empties the heap; memory needs no clearing.
// A held result stalls the back end; the two-entry command queue keeps accepting until full.
module binary_max_heap_queue_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  bmhq_pkg::bmhq_in_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output bmhq_pkg::bmhq_out_t out_data
);
  import bmhq_pkg::*;

  logic      cmd_valid, cmd_take, res_valid, res_take, out_valid_r;
  bmhq_cmd_t cmd;
  bmhq_out_t res, out_r;

  bmhq_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data,
    .cmd_valid, .cmd_take, .cmd
  );

  bmhq_back u_back (
    .clk, .rst_n, .cmd_valid, .cmd_take, .cmd,
    .res_valid, .res_take, .res
  );

  // Result register
  assign res_take = res_valid && (!out_valid_r || out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) out_r <= res;
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

endmodule

@@ tb/binary_max_heap_queue_unit_tb.sv @@
// Testbench for binary_max_heap_queue_unit: directed table, fill and drain, then random heap traffic,
// each result checked against a behavioral max-heap. Depends on bmhq_pkg and the RTL.
module binary_max_heap_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bmhq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  bmhq_in_t  in_data;
  logic      out_empty;
  logic      out_pop;
  bmhq_out_t out_data;

  binary_max_heap_queue_unit dut (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );

  // Predictor state: the heap as the block should hold it
  logic signed [31:0] heap_keys [CAPACITY];
  int                 heap_size;
  bmhq_out_t          pending_results [$];
  int                 error_count;
  int                 cycle_count;
  bit                 stimulus_done;
  bit                 hold_off_req;

  // Directed table; check_now marks rows whose result is written in
  typedef struct {
    logic [1:0]         action;
    logic signed [31:0] value;
    bit                 check_now;
    bmhq_out_t          result;
  } table_row_t;
  table_row_t directed_rows [$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Apply one operation to the predicted heap and return the expected result
  function automatic bmhq_out_t heap_apply(logic [1:0] action, logic signed [31:0] value);
    bmhq_out_t r;
    int pos, par, lc, rc, pick;
    logic signed [31:0] t;
    r = '0;
    r.status = ST_OK;
    if (action == ACT_INSERT) begin
      if (heap_size >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        heap_keys[heap_size] = value;
        pos = heap_size;
        heap_size++;
        while (pos > 0) begin
          par = (pos - 1) / 2;
          if (heap_keys[pos] <= heap_keys[par]) break;
          t = heap_keys[pos]; heap_keys[pos] = heap_keys[par]; heap_keys[par] = t;
          pos = par;
        end
      end
    end else if (action == ACT_REMOVE || action == ACT_PEEK) begin
      if (heap_size == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.result_value = heap_keys[0];
        if (action == ACT_REMOVE) begin
          heap_size--;
          heap_keys[0] = heap_keys[heap_size];
          pos = 0;
          while (1) begin
            lc = 2 * pos + 1;
            rc = 2 * pos + 2;
            if (lc >= heap_size) break;
            // equal children go right
            if (rc >= heap_size) pick = lc;
            else pick = (heap_keys[lc] > heap_keys[rc]) ? lc : rc;
            if (heap_keys[pick] <= heap_keys[pos]) break;
            t = heap_keys[pick]; heap_keys[pick] = heap_keys[pos]; heap_keys[pos] = t;
            pos = pick;
          end
        end
      end
    end
    r.item_count = heap_size[ITEM_W-1:0];
    return r;
  endfunction

  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [31:0] random_key();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed(32'($urandom_range(0, 7)) - 32'd4);
      default: return $signed($urandom());
    endcase
  endfunction

  // One transfer on the input side; the predictor runs when the item is taken
  task automatic push_item(logic [1:0] action, logic signed [31:0] value, bit check_now,
                           bmhq_out_t typed);
    bmhq_out_t predicted;
    in_push <= 1'b1;
    in_data <= '{action: action, value: value};
    do @(posedge clk); while (in_full);
    predicted = heap_apply(action, value);
    if (check_now && predicted !== typed) begin
      $display("%0t table row disagrees with predictor: expected %p actual %p",
               $time, typed, predicted);
      error_count++;
    end
    pending_results.push_back(predicted);
  endtask

  task automatic drop_push();
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic bmhq_out_t res(logic signed [31:0] v, logic [1:0] s, int n);
    bmhq_out_t r;
    r.result_value = v;
    r.status = s;
    r.item_count = n[ITEM_W-1:0];
    return r;
  endfunction

  function automatic void add_row(logic [1:0] a, logic signed [31:0] v, bit c, bmhq_out_t r);
    table_row_t row;
    row.action = a; row.value = v; row.check_now = c; row.result = r;
    directed_rows.push_back(row);
  endfunction

  // Sender
  initial begin
    int mode, n;
    in_push = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    heap_size = 0;
    error_count = 0;
    stimulus_done = 0;
    hold_off_req = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty heap, extremes, unknown action, ties
    add_row(ACT_REMOVE, 0, 1, res(0, ST_EMPTY, 0));
    add_row(ACT_PEEK, 0, 1, res(0, ST_EMPTY, 0));
    add_row(OP_NOP, 32'sh12345678, 1, res(0, ST_OK, 0));
    add_row(ACT_INSERT, 32'sh80000000, 1, res(0, ST_OK, 1));
    add_row(ACT_INSERT, 32'sh7fffffff, 1, res(0, ST_OK, 2));
    add_row(ACT_PEEK, 0, 1, res(32'sh7fffffff, ST_OK, 2));
    add_row(ACT_INSERT, -1, 0, '0);
    add_row(ACT_INSERT, -1, 0, '0);
    add_row(ACT_INSERT, 0, 0, '0);
    add_row(ACT_INSERT, 5, 0, '0);
    add_row(ACT_INSERT, 5, 0, '0);
    add_row(ACT_REMOVE, 0, 1, res(32'sh7fffffff, ST_OK, 6));
    add_row(ACT_REMOVE, 0, 1, res(5, ST_OK, 5));
    add_row(ACT_REMOVE, 0, 1, res(5, ST_OK, 4));
    add_row(ACT_REMOVE, 0, 0, '0);
    add_row(ACT_REMOVE, 0, 0, '0);
    add_row(ACT_REMOVE, 0, 0, '0);
    add_row(ACT_REMOVE, 0, 1, res(32'sh80000000, ST_OK, 0));
    add_row(ACT_REMOVE, 0, 1, res(0, ST_EMPTY, 0));
    foreach (directed_rows[i])
      push_item(directed_rows[i].action, directed_rows[i].value,
                directed_rows[i].check_now, directed_rows[i].result);

    // Fill to capacity, overflow, then drain; receiver holds off meanwhile
    hold_off_req = 1;
    for (int i = 0; i < CAPACITY + 3; i++)
      push_item(ACT_INSERT, random_key(), 0, '0);
    for (int i = 0; i < CAPACITY + 2; i++) begin
      push_item(ACT_REMOVE, 0, 0, '0);
      drop_push();
    end

    // Random phases: grow, mixed, shrink
    n = 0;
    while (n < 800) begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(10, 60)) begin
        int roll;
        logic [1:0] act;
        roll = $urandom_range(0, 99);
        case (mode)
          0: act = (roll < 75) ? ACT_INSERT : (roll < 90) ? ACT_REMOVE : ACT_PEEK;
          1: act = (roll < 40) ? ACT_INSERT : (roll < 80) ? ACT_REMOVE : ACT_PEEK;
          default: act = (roll < 20) ? ACT_INSERT : (roll < 85) ? ACT_REMOVE : ACT_PEEK;
        endcase
        if (roll == 99) act = OP_NOP;
        push_item(act, random_key(), 0, '0);
        drop_push();
        n++;
      end
    end
    in_push <= 1'b0;
    stimulus_done = 1;
  end

  // Receiver with random stalls and one long hold-off while the queue fills
  initial begin
    int stall;
    bit held;
    out_pop = 1'b0;
    held = 0;
    forever begin
      if (hold_off_req && !held) begin
        held = 1;
        out_pop <= 1'b0;
        repeat (200) @(posedge clk);
      end
      stall = gap_length();
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
    end
  end

  // Result checker
  always @(posedge clk) begin
    bmhq_out_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: actual %p", $time, out_data);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.result_value !== want.result_value) begin
          $display("%0t result_value: expected %0d actual %0d", $time,
                   want.result_value, out_data.result_value);
          error_count++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t status: expected %0d actual %0d", $time, want.status,
                   out_data.status);
          error_count++;
        end
        if (out_data.item_count !== want.item_count) begin
          $display("%0t item_count: expected %0d actual %0d", $time,
                   want.item_count, out_data.item_count);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // End of run
  initial begin
    wait (stimulus_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ binary_max_heap_queue_unit.f @@
design/bmhq_pkg.sv
design/bmhq_front.sv
design/bmhq_back.sv
design/binary_max_heap_queue_unit.sv
tb/binary_max_heap_queue_unit_tb.sv
